### rtl/yqrc_pkg.sv
// ----------------------------------------------------------------------------
// yqrc_pkg
// Types and fixed constants shared by the quad color converter modules.
// ----------------------------------------------------------------------------
package yqrc_pkg;

    localparam int NUM_LANES  = 4;
    localparam int LUMA_W     = 8;
    localparam int CHROMA_W   = 8;
    localparam int PIXEL_W    = 32;
    localparam int TERM_W     = 11;
    localparam int SUM_W      = 12;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] BYTE_MAX     = 8'hFF;
    localparam logic [7:0] BYTE_MIN     = 8'h00;

    // Milli-unit values of the conversion coefficients.
    localparam int MILLI_RV = 1140;
    localparam int MILLI_GU = 395;
    localparam int MILLI_GV = 581;
    localparam int MILLI_BU = 2033;

    typedef logic [LUMA_W-1:0]          t_luma;
    typedef logic signed [TERM_W-1:0]   t_term;
    typedef logic [PIXEL_W-1:0]         t_pixel;

    // Chroma terms shared by all four lanes.
    typedef struct packed {
        t_term r_add;
        t_term g_sub;
        t_term b_add;
    } t_chroma_terms;

endpackage

### rtl/yuv_quad_to_rgba_converter_unit.sv
// ----------------------------------------------------------------------------
// yuv_quad_to_rgba_converter_unit
// Converts one 2x2 quad of 4:2:0 luma plus its shared chroma pair into four
// packed pixels (alpha, blue, green, red from the top byte down).
//
//   Channel  Direction  Handshake                 Payload
//   in       input      i_in_valid / o_in_ready   i_y_* (4 x 8b), i_u_byte, i_v_byte
//   out      output     o_out_valid / i_out_ready o_pixel_* (4 x 32b)
//
// Three registered stages: chroma multiply, chroma scaling, then the four
// pixel lanes into the output register. One quad is taken every cycle while
// the output side keeps up. A stall on the output fills the three stages,
// after which o_in_ready drops until the output item is taken.
// Reset clears the stage valid flags only; no clearing pass is needed.
// ----------------------------------------------------------------------------
module yuv_quad_to_rgba_converter_unit #(
    parameter int COEF_FRAC_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_y_top_left,
    input  logic [7:0]  i_y_top_right,
    input  logic [7:0]  i_y_bottom_left,
    input  logic [7:0]  i_y_bottom_right,
    input  logic [7:0]  i_u_byte,
    input  logic [7:0]  i_v_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_pixel_top_left,
    output logic [31:0] o_pixel_top_right,
    output logic [31:0] o_pixel_bottom_left,
    output logic [31:0] o_pixel_bottom_right
);

    localparam int PW = COEF_FRAC_BITS + 11;
    localparam int FIX_ONE = 1 << COEF_FRAC_BITS;
    localparam int COEF_RV = (yqrc_pkg::MILLI_RV * FIX_ONE + 500) / 1000;
    localparam int COEF_GU = (yqrc_pkg::MILLI_GU * FIX_ONE + 500) / 1000;
    localparam int COEF_GV = (yqrc_pkg::MILLI_GV * FIX_ONE + 500) / 1000;
    localparam int COEF_BU = (yqrc_pkg::MILLI_BU * FIX_ONE + 500) / 1000;
    localparam logic signed [PW-1:0] K_RV = PW'(COEF_RV);
    localparam logic signed [PW-1:0] K_GU = PW'(COEF_GU);
    localparam logic signed [PW-1:0] K_GV = PW'(COEF_GV);
    localparam logic signed [PW-1:0] K_BU = PW'(COEF_BU);

    // Pipeline control.
    logic w_adv1;
    logic w_adv2;
    logic w_adv3;

    // Stage 1: chroma products.
    logic                    r_s1_valid;
    yqrc_pkg::t_luma         r_s1_y [yqrc_pkg::NUM_LANES];
    logic signed [PW-1:0]    r_prod_rv;
    logic signed [PW-1:0]    r_prod_gu;
    logic signed [PW-1:0]    r_prod_gv;
    logic signed [PW-1:0]    r_prod_bu;
    logic signed [PW-1:0]    n_prod_rv;
    logic signed [PW-1:0]    n_prod_gu;
    logic signed [PW-1:0]    n_prod_gv;
    logic signed [PW-1:0]    n_prod_bu;
    logic signed [7:0]       w_u;
    logic signed [7:0]       w_v;
    logic signed [PW-1:0]    w_u_x;
    logic signed [PW-1:0]    w_v_x;
    yqrc_pkg::t_luma         w_in_y [yqrc_pkg::NUM_LANES];

    // Stage 2: scaled chroma terms.
    logic                    r_s2_valid;
    yqrc_pkg::t_luma         r_s2_y [yqrc_pkg::NUM_LANES];
    yqrc_pkg::t_chroma_terms r_terms;
    yqrc_pkg::t_chroma_terms n_terms;

    // Stage 3: packed pixels.
    logic                    r_out_valid;
    yqrc_pkg::t_pixel        r_pix [yqrc_pkg::NUM_LANES];
    yqrc_pkg::t_pixel        n_pix [yqrc_pkg::NUM_LANES];

    assign w_adv3     = !r_out_valid || i_out_ready;
    assign w_adv2     = !r_s2_valid || w_adv3;
    assign w_adv1     = !r_s1_valid || w_adv2;
    assign o_in_ready = w_adv1;

    assign w_in_y[0] = i_y_top_left;
    assign w_in_y[1] = i_y_top_right;
    assign w_in_y[2] = i_y_bottom_left;
    assign w_in_y[3] = i_y_bottom_right;

    // Subtracting 128 from a byte is the same as flipping its top bit.
    assign w_u = $signed({~i_u_byte[7], i_u_byte[6:0]});
    assign w_v = $signed({~i_v_byte[7], i_v_byte[6:0]});

    assign w_u_x = {{(PW-8){w_u[7]}}, w_u};
    assign w_v_x = {{(PW-8){w_v[7]}}, w_v};

    always_comb begin
        n_prod_rv = w_v_x * K_RV;
        n_prod_gu = w_u_x * K_GU;
        n_prod_gv = w_v_x * K_GV;
        n_prod_bu = w_u_x * K_BU;
    end

    yqrc_chroma #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_chroma (
        .i_prod_rv (r_prod_rv),
        .i_prod_gu (r_prod_gu),
        .i_prod_gv (r_prod_gv),
        .i_prod_bu (r_prod_bu),
        .o_terms   (n_terms)
    );

    for (genvar k = 0; k < yqrc_pkg::NUM_LANES; k++) begin : g_lane
        yqrc_lane u_lane (
            .i_luma  (r_s2_y[k]),
            .i_terms (r_terms),
            .o_pixel (n_pix[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_s1_valid <= i_in_valid;
            end
            if (w_adv2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_adv3) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1 && i_in_valid) begin
            r_s1_y    <= w_in_y;
            r_prod_rv <= n_prod_rv;
            r_prod_gu <= n_prod_gu;
            r_prod_gv <= n_prod_gv;
            r_prod_bu <= n_prod_bu;
        end
        if (w_adv2 && r_s1_valid) begin
            r_s2_y  <= r_s1_y;
            r_terms <= n_terms;
        end
        if (w_adv3 && r_s2_valid) begin
            r_pix <= n_pix;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_pixel_top_left     = r_pix[0];
    assign o_pixel_top_right    = r_pix[1];
    assign o_pixel_bottom_left  = r_pix[2];
    assign o_pixel_bottom_right = r_pix[3];

    // A held output with both inner stages full must back up the input.
    a_full_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s2_valid && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while the whole pipeline is stalled");

    // An item in the middle stage moves to the output when the output frees up.
    a_s2_moves_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && w_adv3) |=> r_out_valid)
        else $error("item lost between the lanes and the output register");

    // An accepted item always reaches the product stage.
    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_s1_valid)
        else $error("accepted item did not enter the multiply stage");

    // Delivered pixels carry an opaque alpha byte; top-left and bottom-right are checked.
    a_alpha_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pixel_top_left[31:24] == yqrc_pkg::ALPHA_OPAQUE
                      && o_pixel_bottom_right[31:24] == yqrc_pkg::ALPHA_OPAQUE))
        else $error("output pixel with a wrong alpha byte");

endmodule

### rtl/yqrc_chroma.sv
// ----------------------------------------------------------------------------
// yqrc_chroma
// Sums the green products and scales every chroma product down by the
// fraction width, truncating toward zero.
// ----------------------------------------------------------------------------
module yqrc_chroma #(
    parameter int COEF_FRAC_BITS = 10,
    localparam int PW = COEF_FRAC_BITS + 11
) (
    input  logic signed [PW-1:0]  i_prod_rv,
    input  logic signed [PW-1:0]  i_prod_gu,
    input  logic signed [PW-1:0]  i_prod_gv,
    input  logic signed [PW-1:0]  i_prod_bu,
    output yqrc_pkg::t_chroma_terms o_terms
);

    logic signed [PW:0] w_g_sum;

    // The magnitude is shifted and the sign put back, so negative values
    // round toward zero rather than toward minus infinity.
    function automatic yqrc_pkg::t_term trunc_scale(input logic signed [PW:0] p);
        logic [PW:0] mag;
        logic [PW:0] shifted;
        logic [PW:0] signed_res;
        mag        = p[PW] ? (~p + 1'b1) : p;
        shifted    = mag >> COEF_FRAC_BITS;
        signed_res = p[PW] ? (~shifted + 1'b1) : shifted;
        return signed_res[yqrc_pkg::TERM_W-1:0];
    endfunction

    assign w_g_sum = {i_prod_gu[PW-1], i_prod_gu} + {i_prod_gv[PW-1], i_prod_gv};

    always_comb begin
        o_terms.r_add = trunc_scale({i_prod_rv[PW-1], i_prod_rv});
        o_terms.g_sub = trunc_scale(w_g_sum);
        o_terms.b_add = trunc_scale({i_prod_bu[PW-1], i_prod_bu});
    end

endmodule

### rtl/yqrc_lane.sv
// ----------------------------------------------------------------------------
// yqrc_lane
// One pixel lane: adds the shared chroma terms to a luma, clamps each
// channel to a byte and packs the pixel.
// ----------------------------------------------------------------------------
module yqrc_lane (
    input  yqrc_pkg::t_luma         i_luma,
    input  yqrc_pkg::t_chroma_terms i_terms,
    output yqrc_pkg::t_pixel        o_pixel
);

    logic signed [yqrc_pkg::SUM_W-1:0] w_y;
    logic signed [yqrc_pkg::SUM_W-1:0] w_r;
    logic signed [yqrc_pkg::SUM_W-1:0] w_g;
    logic signed [yqrc_pkg::SUM_W-1:0] w_b;
    logic [7:0] w_r8;
    logic [7:0] w_g8;
    logic [7:0] w_b8;

    function automatic logic [7:0] clamp_byte(input logic signed [yqrc_pkg::SUM_W-1:0] x);
        logic [7:0] res;
        if (x < 0) begin
            res = yqrc_pkg::BYTE_MIN;
        end else if (x > $signed({4'b0000, yqrc_pkg::BYTE_MAX})) begin
            res = yqrc_pkg::BYTE_MAX;
        end else begin
            res = x[7:0];
        end
        return res;
    endfunction

    assign w_y = $signed({4'b0000, i_luma});
    assign w_r = w_y + {i_terms.r_add[yqrc_pkg::TERM_W-1], i_terms.r_add};
    assign w_g = w_y - {i_terms.g_sub[yqrc_pkg::TERM_W-1], i_terms.g_sub};
    assign w_b = w_y + {i_terms.b_add[yqrc_pkg::TERM_W-1], i_terms.b_add};

    assign w_r8 = clamp_byte(w_r);
    assign w_g8 = clamp_byte(w_g);
    assign w_b8 = clamp_byte(w_b);

    assign o_pixel = {yqrc_pkg::ALPHA_OPAQUE, w_b8, w_g8, w_r8};

endmodule

### sim/yuv_quad_to_rgba_converter_unit_tb.sv
// ----------------------------------------------------------------------------
// yuv_quad_to_rgba_converter_unit_tb
// Drives luma quads and chroma pairs into the converter and checks each set
// of four packed pixels against a fixed-point color conversion computed in
// the bench. Directed corner quads come first, then random streams with
// idle cycles on both sides, a stretch with no idling, and a pause that
// lets the pipeline drain completely.
// ----------------------------------------------------------------------------
module yuv_quad_to_rgba_converter_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS  = 10;
    localparam int IDLE_PCT   = 33;
    localparam int DRAIN_CYC  = 20;
    localparam int CHROMA_MID = 128;

    typedef struct packed {
        yqrc_pkg::t_pixel top_left;
        yqrc_pkg::t_pixel top_right;
        yqrc_pkg::t_pixel bottom_left;
        yqrc_pkg::t_pixel bottom_right;
    } t_pixel_quad;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_y_top_left;
    logic [7:0]  i_y_top_right;
    logic [7:0]  i_y_bottom_left;
    logic [7:0]  i_y_bottom_right;
    logic [7:0]  i_u_byte;
    logic [7:0]  i_v_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [31:0] o_pixel_top_left;
    logic [31:0] o_pixel_top_right;
    logic [31:0] o_pixel_bottom_left;
    logic [31:0] o_pixel_bottom_right;

    t_pixel_quad expected_quads[$];
    int          error_count = 0;
    bit          no_idle     = 1'b0;

    yuv_quad_to_rgba_converter_unit #(
        .COEF_FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_y_top_left        (i_y_top_left),
        .i_y_top_right       (i_y_top_right),
        .i_y_bottom_left     (i_y_bottom_left),
        .i_y_bottom_right    (i_y_bottom_right),
        .i_u_byte            (i_u_byte),
        .i_v_byte            (i_v_byte),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_pixel_top_left    (o_pixel_top_left),
        .o_pixel_top_right   (o_pixel_top_right),
        .o_pixel_bottom_left (o_pixel_bottom_left),
        .o_pixel_bottom_right(o_pixel_bottom_right)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400us;
        $display("DONE: errors detected");
        $finish;
    end

    // Coefficient in fixed point, rounded to nearest with ties up.
    function automatic int fix_coef(input int milli);
        return (milli * (1 << FRAC_BITS) + 500) / 1000;
    endfunction

    // Scale a signed product down, truncating toward zero.
    function automatic int scale_toward_zero(input int p);
        if (p < 0) begin
            return -((-p) >>> FRAC_BITS);
        end
        return p >>> FRAC_BITS;
    endfunction

    function automatic logic [7:0] saturate_byte(input int x);
        if (x < 0) begin
            return 8'h00;
        end
        if (x > 255) begin
            return 8'hFF;
        end
        return x[7:0];
    endfunction

    function automatic t_pixel_quad convert_quad(input yqrc_pkg::t_luma ytl, ytr, ybl, ybr,
                                                 input logic [7:0] u_b, v_b);
        int               u_c;
        int               v_c;
        int               r_add;
        int               g_sub;
        int               b_add;
        int               lum;
        yqrc_pkg::t_luma  lumas[4];
        yqrc_pkg::t_pixel pix[4];
        t_pixel_quad      q;
        u_c    = int'(u_b) - CHROMA_MID;
        v_c    = int'(v_b) - CHROMA_MID;
        r_add  = scale_toward_zero(fix_coef(yqrc_pkg::MILLI_RV) * v_c);
        g_sub  = scale_toward_zero(fix_coef(yqrc_pkg::MILLI_GU) * u_c
                                   + fix_coef(yqrc_pkg::MILLI_GV) * v_c);
        b_add  = scale_toward_zero(fix_coef(yqrc_pkg::MILLI_BU) * u_c);
        lumas  = '{ytl, ytr, ybl, ybr};
        for (int k = 0; k < 4; k++) begin
            lum    = int'(lumas[k]);
            pix[k] = {8'hFF, saturate_byte(lum + b_add), saturate_byte(lum - g_sub),
                      saturate_byte(lum + r_add)};
        end
        q.top_left     = pix[0];
        q.top_right    = pix[1];
        q.bottom_left  = pix[2];
        q.bottom_right = pix[3];
        return q;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Send one quad: optional idle cycles, then hold valid until accepted.
    task automatic send_quad(input yqrc_pkg::t_luma ytl, ytr, ybl, ybr,
                             input logic [7:0] u_b, v_b);
        if (!no_idle) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid       <= 1'b1;
        i_y_top_left     <= ytl;
        i_y_top_right    <= ytr;
        i_y_bottom_left  <= ybl;
        i_y_bottom_right <= ybr;
        i_u_byte         <= u_b;
        i_v_byte         <= v_b;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        expected_quads.push_back(convert_quad(ytl, ytr, ybl, ybr, u_b, v_b));
    endtask

    // Mostly uniform bytes, with the range ends and the chroma midpoint mixed in.
    function automatic logic [7:0] pick_byte();
        logic [7:0] corners[5];
        corners = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF};
        if ($urandom_range(7) == 0) begin
            return corners[$urandom_range(4)];
        end
        return 8'($urandom_range(255));
    endfunction

    task automatic send_random_quads(input int count);
        for (int n = 0; n < count; n++) begin
            send_quad(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                      pick_byte(), pick_byte());
        end
    endtask

    task automatic wait_for_drain();
        while (expected_quads.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic test_directed_corners();
        send_quad(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_quad(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_quad(8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'h80);
        send_quad(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h80);
        send_quad(8'h00, 8'h55, 8'hAA, 8'hFF, 8'h80, 8'h80);
        send_quad(8'h00, 8'h55, 8'hAA, 8'hFF, 8'h00, 8'h00);
        send_quad(8'h00, 8'h55, 8'hAA, 8'hFF, 8'hFF, 8'hFF);
        send_quad(8'h00, 8'h55, 8'hAA, 8'hFF, 8'h00, 8'hFF);
        send_quad(8'h00, 8'h55, 8'hAA, 8'hFF, 8'hFF, 8'h00);
        // Chroma just off center exercises truncation toward zero on both signs.
        send_quad(8'h10, 8'h80, 8'hF0, 8'h40, 8'h7F, 8'h81);
        send_quad(8'h10, 8'h80, 8'hF0, 8'h40, 8'h81, 8'h7F);
        send_quad(8'h01, 8'hFE, 8'h80, 8'h7F, 8'h01, 8'hFE);
        send_quad(8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80);
        send_quad(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h00);
        send_quad(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55);
        send_quad(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA);
    endtask

    task automatic test_random_stream();
        send_random_quads(1100);
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        send_random_quads(300);
        no_idle = 1'b0;
    endtask

    // The sender holds off until the pipeline is empty, then restarts.
    task automatic test_drain_and_restart();
        send_random_quads(150);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait_for_drain();
        send_random_quads(150);
    endtask

    // Output side: check accepted items, then choose the next ready value.
    initial begin
        t_pixel_quad want;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (expected_quads.size() == 0) begin
                    report_mismatch("output item with nothing pending");
                end else begin
                    want = expected_quads.pop_front();
                    if (o_pixel_top_left !== want.top_left) begin
                        report_mismatch($sformatf("top_left got %08h want %08h",
                                                  o_pixel_top_left, want.top_left));
                    end
                    if (o_pixel_top_right !== want.top_right) begin
                        report_mismatch($sformatf("top_right got %08h want %08h",
                                                  o_pixel_top_right, want.top_right));
                    end
                    if (o_pixel_bottom_left !== want.bottom_left) begin
                        report_mismatch($sformatf("bottom_left got %08h want %08h",
                                                  o_pixel_bottom_left, want.bottom_left));
                    end
                    if (o_pixel_bottom_right !== want.bottom_right) begin
                        report_mismatch($sformatf("bottom_right got %08h want %08h",
                                                  o_pixel_bottom_right, want.bottom_right));
                    end
                end
            end
            if (no_idle) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_y_top_left     <= 8'h00;
        i_y_top_right    <= 8'h00;
        i_y_bottom_left  <= 8'h00;
        i_y_bottom_right <= 8'h00;
        i_u_byte         <= 8'h00;
        i_v_byte         <= 8'h00;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_corners();
        test_random_stream();
        test_back_to_back();
        test_drain_and_restart();
        i_in_valid <= 1'b0;
        wait_for_drain();
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (error_count == 0 && expected_quads.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
